[rtl/assert_macros.svh]
// Assertion macros included by the message hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sha256_pkg.sv]
// Types, constants and round functions of the SHA-256 hasher.
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_OUTPUT
	} state_t;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] LAST_BYTE = 6'd63;
	localparam logic [5:0] LAST_RND  = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd7;

	localparam logic [31:0] IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'h428A2F98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hB5C0FBCF;
			6'd3:  k = 32'hE9B5DBA5;
			6'd4:  k = 32'h3956C25B;
			6'd5:  k = 32'h59F111F1;
			6'd6:  k = 32'h923F82A4;
			6'd7:  k = 32'hAB1C5ED5;
			6'd8:  k = 32'hD807AA98;
			6'd9:  k = 32'h12835B01;
			6'd10: k = 32'h243185BE;
			6'd11: k = 32'h550C7DC3;
			6'd12: k = 32'h72BE5D74;
			6'd13: k = 32'h80DEB1FE;
			6'd14: k = 32'h9BDC06A7;
			6'd15: k = 32'hC19BF174;
			6'd16: k = 32'hE49B69C1;
			6'd17: k = 32'hEFBE4786;
			6'd18: k = 32'h0FC19DC6;
			6'd19: k = 32'h240CA1CC;
			6'd20: k = 32'h2DE92C6F;
			6'd21: k = 32'h4A7484AA;
			6'd22: k = 32'h5CB0A9DC;
			6'd23: k = 32'h76F988DA;
			6'd24: k = 32'h983E5152;
			6'd25: k = 32'hA831C66D;
			6'd26: k = 32'hB00327C8;
			6'd27: k = 32'hBF597FC7;
			6'd28: k = 32'hC6E00BF3;
			6'd29: k = 32'hD5A79147;
			6'd30: k = 32'h06CA6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27B70A85;
			6'd33: k = 32'h2E1B2138;
			6'd34: k = 32'h4D2C6DFC;
			6'd35: k = 32'h53380D13;
			6'd36: k = 32'h650A7354;
			6'd37: k = 32'h766A0ABB;
			6'd38: k = 32'h81C2C92E;
			6'd39: k = 32'h92722C85;
			6'd40: k = 32'hA2BFE8A1;
			6'd41: k = 32'hA81A664B;
			6'd42: k = 32'hC24B8B70;
			6'd43: k = 32'hC76C51A3;
			6'd44: k = 32'hD192E819;
			6'd45: k = 32'hD6990624;
			6'd46: k = 32'hF40E3585;
			6'd47: k = 32'h106AA070;
			6'd48: k = 32'h19A4C116;
			6'd49: k = 32'h1E376C08;
			6'd50: k = 32'h2748774C;
			6'd51: k = 32'h34B0BCB5;
			6'd52: k = 32'h391C0CB3;
			6'd53: k = 32'h4ED8AA4A;
			6'd54: k = 32'h5B9CCA4F;
			6'd55: k = 32'h682E6FF3;
			6'd56: k = 32'h748F82EE;
			6'd57: k = 32'h78A5636F;
			6'd58: k = 32'h84C87814;
			6'd59: k = 32'h8CC70208;
			6'd60: k = 32'h90BEFFFA;
			6'd61: k = 32'hA4506CEB;
			6'd62: k = 32'hBEF9A3F7;
			default: k = 32'hC67178F2;
		endcase
		return k;
	endfunction

endpackage

[rtl/sha256_if.sv]
// Valid/ready channel interfaces for message bytes and digest words.
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/sha256_message_hasher.sv]
// SHA-256 message hasher: byte input, one compression round per cycle, digest word output.
//
//   channel     dir  payload                                   handshake
//   msg_in      in   data_byte[8], has_byte, end_of_message    valid/ready
//   digest_out  out  digest_word[32], word_index[3], last_word valid/ready
//
// Bytes are taken only in the idle state, not while a block is padded, compressed or folded, nor during output.
// Each full 64-byte block runs all its compression rounds, then the final state folds it into the hash.
// An end item adds one pad byte per cycle up to the block end, so 1 to 2 padded blocks.
// Digest words leave one per cycle when the sink is ready; input stalls until all eight go.
// Reset loads the initial hash values and clears fill and length counts.
`include "assert_macros.svh"

module sha256_message_hasher (
	input  logic              clk,
	input  logic              arst_n,
	sha256_in_if.sink         msg_in,
	sha256_out_if.source      digest_out
);

	sha256_pkg::state_t state_q, state_d;

	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [511:0] sched_q;
	logic [5:0]   fill_q;
	logic [60:0]  len_q;
	logic [5:0]   rnd_q;
	logic [2:0]   idx_q;
	logic         end_q;
	logic         mark_q;
	logic         lenblk_q;

	logic        in_acc, out_acc;
	logic        byte_take, shift_en, start_rnd;
	logic [7:0]  shift_byte, pad_byte;
	logic [63:0] bit_len;

	// round datapath
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2, ch, maj;

	assign in_acc    = msg_in.valid & msg_in.ready;
	assign out_acc   = digest_out.valid & digest_out.ready;
	assign byte_take = in_acc & msg_in.has_byte;
	assign bit_len   = {len_q, 3'b000};
	assign start_rnd = (state_d == sha256_pkg::ST_ROUND) && (state_q != sha256_pkg::ST_ROUND);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (msg_in.has_byte && fill_q == sha256_pkg::LAST_BYTE)
						state_d = sha256_pkg::ST_ROUND;
					else if (msg_in.end_of_message)
						state_d = sha256_pkg::ST_PAD;
				end
			end
			sha256_pkg::ST_PAD: begin
				if (fill_q == sha256_pkg::LAST_BYTE)
					state_d = sha256_pkg::ST_ROUND;
			end
			sha256_pkg::ST_ROUND: begin
				if (rnd_q == sha256_pkg::LAST_RND)
					state_d = sha256_pkg::ST_FINAL;
			end
			sha256_pkg::ST_FINAL: begin
				if (!end_q)
					state_d = sha256_pkg::ST_IDLE;
				else if (lenblk_q)
					state_d = sha256_pkg::ST_OUTPUT;
				else
					state_d = sha256_pkg::ST_PAD;
			end
			sha256_pkg::ST_OUTPUT: begin
				if (out_acc && idx_q == sha256_pkg::LAST_WORD)
					state_d = sha256_pkg::ST_IDLE;
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	// outputs and byte-path controls
	always_comb begin
		msg_in.ready           = (state_q == sha256_pkg::ST_IDLE);
		digest_out.valid       = (state_q == sha256_pkg::ST_OUTPUT);
		digest_out.digest_word = h_q[0];
		digest_out.word_index  = idx_q;
		digest_out.last_word   = (idx_q == sha256_pkg::LAST_WORD);

		// marker first, then zeros; length bytes fill the tail of the last block
		if (!mark_q)
			pad_byte = sha256_pkg::PAD_MARK;
		else if (lenblk_q && fill_q >= sha256_pkg::LEN_START)
			pad_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];
		else
			pad_byte = 8'h00;

		shift_en   = byte_take || (state_q == sha256_pkg::ST_PAD);
		shift_byte = byte_take ? msg_in.data_byte : pad_byte;
	end

	// one compression round; the schedule window slides by a word each round
	always_comb begin
		w0  = sched_q[511:480];
		w1  = sched_q[479:448];
		w9  = sched_q[223:192];
		w14 = sched_q[63:32];
		w_new = sha256_pkg::small_sigma1(w14) + w9 + sha256_pkg::small_sigma0(w1) + w0;
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + sha256_pkg::big_sigma1(v_q[4]) + ch + sha256_pkg::round_k(rnd_q) + w0;
		t2  = sha256_pkg::big_sigma0(v_q[0]) + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha256_pkg::ST_IDLE;
			fill_q   <= '0;
			len_q    <= '0;
			rnd_q    <= '0;
			idx_q    <= '0;
			end_q    <= 1'b0;
			mark_q   <= 1'b0;
			lenblk_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= sha256_pkg::IV[i];
		end else begin
			state_q <= state_d;

			if (shift_en)
				fill_q <= fill_q + 6'd1;
			if (byte_take)
				len_q <= len_q + 61'd1;

			if (in_acc && msg_in.end_of_message) begin
				end_q    <= 1'b1;
				mark_q   <= 1'b0;
				lenblk_q <= 1'b0;
			end

			if (state_q == sha256_pkg::ST_PAD && !mark_q) begin
				mark_q   <= 1'b1;
				lenblk_q <= (fill_q < sha256_pkg::LEN_START);
			end

			if (state_q == sha256_pkg::ST_FINAL) begin
				for (int i = 0; i < 8; i++)
					h_q[i] <= h_q[i] + v_q[i];
				// marker already placed: the next padded block carries the length
				if (end_q && !lenblk_q)
					lenblk_q <= mark_q;
			end

			if (start_rnd)
				rnd_q <= '0;
			else if (state_q == sha256_pkg::ST_ROUND)
				rnd_q <= rnd_q + 6'd1;

			if (out_acc) begin
				idx_q <= idx_q + 3'd1;
				for (int i = 0; i < 7; i++)
					h_q[i] <= h_q[i + 1];
				h_q[7] <= h_q[0];
				if (idx_q == sha256_pkg::LAST_WORD) begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= sha256_pkg::IV[i];
					len_q  <= '0;
					end_q  <= 1'b0;
				end
			end
		end
	end

	// payload: byte line doubles as the schedule window, working variables
	always_ff @(posedge clk) begin
		if (shift_en)
			sched_q <= {sched_q[503:0], shift_byte};
		else if (state_q == sha256_pkg::ST_ROUND)
			sched_q <= {sched_q[479:0], w_new};

		if (start_rnd) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end else if (state_q == sha256_pkg::ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	`ASSERT_NOW(a_no_overlap, clk, arst_n, digest_out.valid, !msg_in.ready, "output while taking input")
	`ASSERT_NEXT(a_round_end, clk, arst_n, state_q == sha256_pkg::ST_ROUND && rnd_q == sha256_pkg::LAST_RND, state_q == sha256_pkg::ST_FINAL, "round count overrun")
	`ASSERT_NEXT(a_block_full, clk, arst_n, shift_en && fill_q == sha256_pkg::LAST_BYTE, state_q == sha256_pkg::ST_ROUND && rnd_q == 6'd0 && fill_q == 6'd0, "full block not compressed")
	`ASSERT_NEXT(a_digest_done, clk, arst_n, out_acc && idx_q == sha256_pkg::LAST_WORD, state_q == sha256_pkg::ST_IDLE && fill_q == 6'd0 && len_q == 61'd0 && !end_q, "state not cleared after digest")

endmodule
